@@ sv/arrs_pkg.sv @@
// ----------------------------------------------------------------------------
// arrs_pkg: shared constants and types for the register replica server
// Field widths, command and reply codes, configuration register indexes.
// ----------------------------------------------------------------------------
package arrs_pkg;

	localparam int CMD_W   = 2;
	localparam int CID_W   = 6;
	localparam int TS_W    = 32;
	localparam int VAL_W   = 32;
	localparam int OP_W    = 32;
	localparam int CNT_W   = 8;
	localparam int CFG_W   = 7;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_CLIENTS_DEF = 64;

	// commands
	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELAY   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_INVALID = 2'd3;

	// reply kinds
	localparam logic [CMD_W-1:0] KIND_WRITE_ACK = 2'd0;
	localparam logic [CMD_W-1:0] KIND_RELAY     = 2'd1;
	localparam logic [CMD_W-1:0] KIND_READ_ACK  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CLIENTS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SERVERS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	// one client table entry
	typedef struct packed {
		logic [OP_W-1:0]  last_op;
		logic [CNT_W-1:0] relay_cnt;
	} entry_t;

	localparam int ENTRY_W = OP_W + CNT_W;

endpackage

@@ sv/atomic_register_replica_server.sv @@
// ----------------------------------------------------------------------------
// atomic_register_replica_server_core: replica of a quorum atomic register
// Keeps the timestamp/value pair and a per-client table of newest operation
// number and relay count; answers writes, reads and read relays.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  command   | start, busy            | command, client_id, timestamp,
//            |                        | data_value, op_number
//  reply     | reply_strobe (1 cycle) | reply_kind, reply_timestamp, reply_value,
//            |                        | reply_client, reply_op
//  config    | cfg_we                 | cfg_index, cfg_wdata
//
// Flow: a word is taken when start is high and busy low. The table read is
// issued then and the word goes into the stage-1 registers; while it is there
// the entry comes back, a newer timestamp from a write or relay is adopted, a
// relay writes its entry back and the reply register is loaded. So busy is
// high for one cycle and no new word is taken until the table's
// read-modify-write is through. Reset sets the configuration (no clients,
// one server, no failures), clears the stored pair and one valid flop per
// table entry at once (an entry not yet written reads as zero): no clearing
// pass. Invalid commands and unknown clients are dropped on acceptance. The
// receiver cannot stall: each reply is shown for exactly one cycle.
//
module atomic_register_replica_server_core #(
	parameter int MAX_CLIENTS = arrs_pkg::MAX_CLIENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command words
	input  logic                          start,
	output logic                          busy,
	input  logic [arrs_pkg::CMD_W-1:0]    command,
	input  logic [arrs_pkg::CID_W-1:0]    client_id,
	input  logic [arrs_pkg::TS_W-1:0]     timestamp,
	input  logic [arrs_pkg::VAL_W-1:0]    data_value,
	input  logic [arrs_pkg::OP_W-1:0]     op_number,
	// configuration
	input  logic                          cfg_we,
	input  logic [arrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arrs_pkg::CFG_W-1:0]    cfg_wdata,
	// replies
	output logic                          reply_strobe,
	output logic [arrs_pkg::CMD_W-1:0]    reply_kind,
	output logic [arrs_pkg::TS_W-1:0]     reply_timestamp,
	output logic [arrs_pkg::VAL_W-1:0]    reply_value,
	output logic [arrs_pkg::CID_W-1:0]    reply_client,
	output logic [arrs_pkg::OP_W-1:0]     reply_op
);

	import arrs_pkg::*;

	localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam logic [8:0] MAX_C = 9'(MAX_CLIENTS);

	// configuration registers
	logic [CFG_W-1:0] num_clients_q;
	logic [CFG_W-1:0] num_servers_q;
	logic [CFG_W-1:0] max_failures_q;

	// stored pair
	logic [TS_W-1:0]  stored_ts_q;
	logic [VAL_W-1:0] stored_val_q;

	// per-entry valid flags for the client table
	logic [MAX_CLIENTS-1:0] entry_vld_q;

	// stage 1: table read in flight
	logic             valid_s1;
	logic [CMD_W-1:0] cmd_s1;
	logic [CID_W-1:0] cid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [TS_W-1:0]  ts_s1;
	logic [VAL_W-1:0] val_s1;
	logic [OP_W-1:0]  op_s1;

	// reply register
	logic             strobe_q;
	logic [CMD_W-1:0] kind_q;
	logic [TS_W-1:0]  rts_q;
	logic [VAL_W-1:0] rval_q;
	logic [CID_W-1:0] rcid_q;
	logic [OP_W-1:0]  rop_q;

	logic             accept;
	logic             known;
	logic [8:0]       cid_ext;
	logic [IDX_W-1:0] idx_in;

	entry_t           rd_entry;
	entry_t           cur;
	entry_t           nxt;
	logic             tab_we;
	logic             adopt;
	logic [TS_W-1:0]  new_ts;
	logic [VAL_W-1:0] new_val;
	logic [CFG_W:0]   quorum;
	logic             quorum_ok;
	logic             read_ack;
	logic [CNT_W-1:0] cnt_a;

	// ---- acceptance and filtering ----
	assign accept  = start && !busy;
	assign cid_ext = 9'(client_id);
	assign idx_in  = cid_ext[IDX_W-1:0];
	assign known   = (command != CMD_INVALID)
		&& ({1'b0, client_id} < num_clients_q)
		&& (cid_ext < MAX_C);
	assign busy    = valid_s1;

	// ---- client table ----
	arrs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_CLIENTS)
	) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (idx_s1),
		.wdata (nxt),
		.re    (accept),
		.raddr (idx_in),
		.rdata (rd_entry)
	);

	// ---- update logic ----
	always_comb begin
		// never-written entry reads as zero
		cur = entry_vld_q[idx_s1] ? rd_entry : '0;

		// relay bookkeeping
		nxt = cur;
		if (cur.last_op < op_s1) begin
			nxt.last_op   = op_s1;
			nxt.relay_cnt = CNT_W'(1);
		end
		cnt_a = nxt.relay_cnt;
		if (nxt.last_op == op_s1 && cnt_a < CNT_MAX) begin
			cnt_a = cnt_a + CNT_W'(1);
		end
		nxt.relay_cnt = cnt_a;

		// quorum = servers - failures, signed
		quorum    = {1'b0, num_servers_q} - {1'b0, max_failures_q};
		quorum_ok = !quorum[CFG_W] && (quorum != '0);
		read_ack  = valid_s1 && (cmd_s1 == CMD_RELAY) && quorum_ok
			&& (cnt_a == CNT_W'(quorum[CFG_W-1:0]));
		if (read_ack) begin
			nxt.relay_cnt = CNT_W'(1);
		end

		tab_we = valid_s1 && (cmd_s1 == CMD_RELAY);

		// timestamp/value adoption on write and relay
		adopt   = valid_s1 && (cmd_s1 != CMD_READ) && (stored_ts_q < ts_s1);
		new_ts  = adopt ? ts_s1  : stored_ts_q;
		new_val = adopt ? val_s1 : stored_val_q;
	end

	// ---- control and state registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clients_q  <= '0;
			num_servers_q  <= CFG_W'(1);
			max_failures_q <= '0;
			stored_ts_q    <= '0;
			stored_val_q   <= '0;
			entry_vld_q    <= '0;
			valid_s1       <= 1'b0;
			strobe_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_CLIENTS:  num_clients_q  <= cfg_wdata;
					REG_NUM_SERVERS:  num_servers_q  <= cfg_wdata;
					REG_MAX_FAILURES: max_failures_q <= cfg_wdata;
					default: ;
				endcase
			end
			valid_s1 <= accept && known;
			if (adopt) begin
				stored_ts_q  <= ts_s1;
				stored_val_q <= val_s1;
			end
			if (tab_we) begin
				entry_vld_q[idx_s1] <= 1'b1;
			end
			strobe_q <= valid_s1 && (cmd_s1 != CMD_RELAY || read_ack);
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			cid_s1 <= client_id;
			idx_s1 <= idx_in;
			ts_s1  <= timestamp;
			val_s1 <= data_value;
			op_s1  <= op_number;
		end
		if (valid_s1) begin
			rts_q  <= new_ts;
			rval_q <= new_val;
			rcid_q <= cid_s1;
			case (cmd_s1)
				CMD_WRITE: begin
					kind_q <= KIND_WRITE_ACK;
					rop_q  <= '0;
				end
				CMD_READ: begin
					kind_q <= KIND_RELAY;
					rop_q  <= op_s1;
				end
				default: begin
					kind_q <= KIND_READ_ACK;
					rop_q  <= op_s1;
				end
			endcase
		end
	end

	assign reply_strobe    = strobe_q;
	assign reply_kind      = kind_q;
	assign reply_timestamp = rts_q;
	assign reply_value     = rval_q;
	assign reply_client    = rcid_q;
	assign reply_op        = rop_q;

	// ---- assertions ----
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		reply_strobe |-> $past(busy))
		else $error("reply without a word in flight");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		reply_strobe |-> (reply_kind == KIND_WRITE_ACK || reply_kind == KIND_RELAY
			|| reply_kind == KIND_READ_ACK))
		else $error("illegal reply kind");

	a_known_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && known) |=> busy)
		else $error("accepted word did not enter the table stage");

	a_write_always_acked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1 != CMD_RELAY) |=> reply_strobe)
		else $error("write or read gave no reply");

endmodule

@@ sv/arrs_ram.sv @@
// ----------------------------------------------------------------------------
// arrs_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module arrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
